@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion helpers
// concurrent property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge outside reset
`define PT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property check failed");
// condition must never be seen at a rising edge outside reset
`define PT_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define PT_ASSERT(lbl, clk, rst, prop)
`define PT_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ hw/rtl/ptrail_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrail_pkg
// shared types and constants of the path trail interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptrail_pkg;

   // output coordinate width, sets the saturation bounds
   localparam int COORD_BITS = 16;

   // request and response payloads
   typedef struct packed {
      logic               mode;
      logic [7:0]         point_index;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic [23:0]        query_time;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic               last;
   } rsp_data_type;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ROW_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_XYZ    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIL_COUNT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIL_SPACING = 3'd6;

   // remainder unit command and status
   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [8:0]  divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      logic [8:0] remainder;
   } rem_stat_type;

   // interpolate and transform unit status
   typedef struct packed {
      logic               done;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } xf_stat_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_RDA,
      ST_RDB,
      ST_GO,
      ST_XF,
      ST_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      XF_IDLE,
      XF_INTERP,
      XF_MUL,
      XF_ADD,
      XF_FIN
   } xf_state_type;

endpackage

@@ hw/rtl/ptrail_ram.sv @@
// ----------------------------------------------------------------------------
// ptrail_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrail_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ptrail_rem.sv @@
// ----------------------------------------------------------------------------
// ptrail_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrail_rem
   import ptrail_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rem_cmd_type  cmd,
   output rem_stat_type stat
);

   logic        busy_ff;
   logic        done_ff;
   logic [3:0]  cnt_ff;
   logic [8:0]  rem_ff;
   logic [15:0] dvd_ff;
   logic [8:0]  dvs_ff;

   logic [9:0]  trial;
   logic [9:0]  trial_sub;
   logic [8:0]  rem_in;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial     = {rem_ff, dvd_ff[15]};
      trial_sub = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = trial_sub[8:0];
      end else begin
         rem_in = trial[8:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         dvd_ff <= cmd.dividend;
         dvs_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[14:0], 1'b0};
      end
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;

endmodule

@@ hw/rtl/ptrail_xform.sv @@
// ----------------------------------------------------------------------------
// ptrail_xform
// interpolates two waypoints, rotates, offsets and saturates one point
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrail_xform
   import ptrail_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] a_point,
   input  logic [47:0] b_point,
   input  logic [7:0]  frac,
   input  logic [47:0] rot_row_x,
   input  logic [47:0] rot_row_y,
   input  logic [47:0] rot_row_z,
   input  logic [47:0] offset_xyz,
   output xf_stat_type stat
);

   localparam logic signed [25:0] SAT_HI = 26'((1 << (COORD_BITS - 1)) - 1);
   localparam logic signed [25:0] SAT_LO = -SAT_HI - 26'sd1;
   localparam logic [25:0]        MASK   = 26'((1 << COORD_BITS) - 1);
   localparam logic signed [41:0] HALF   = 42'sd8388608;

   // coordinate c of a packed triple, x in the low bits
   function automatic logic signed [15:0] coord_pick(input logic [47:0] w,
                                                     input logic [1:0] sel);
      logic signed [15:0] v;
      case (sel)
         2'd0:    v = w[15:0];
         2'd1:    v = w[31:16];
         default: v = w[47:32];
      endcase
      return v;
   endfunction

   // rotation coefficient for column c, x column in the high bits
   function automatic logic signed [15:0] coef_pick(input logic [47:0] w,
                                                    input logic [1:0] sel);
      logic signed [15:0] v;
      case (sel)
         2'd0:    v = w[47:32];
         2'd1:    v = w[31:16];
         default: v = w[15:0];
      endcase
      return v;
   endfunction

   xf_state_type       state_ff, state_in;
   logic [1:0]         c_ff;
   logic [1:0]         r_ff;
   logic               done_ff;
   logic [47:0]        a_ff;
   logic [47:0]        b_ff;
   logic [7:0]         frac_ff;
   logic signed [23:0] px_ff, py_ff, pz_ff;
   logic signed [39:0] prod_ff;
   logic signed [41:0] acc_ff;
   logic signed [15:0] rx_ff, ry_ff, rz_ff;

   logic               ld_en, interp_en, mul_en, add_en, fin_en;
   logic               last_col, last_row;

   logic signed [15:0] a_c, b_c, coef, off;
   logic signed [16:0] diff;
   logic signed [25:0] dprod, pval;
   logic signed [23:0] p_new, p_cur;
   logic [47:0]        row;
   logic signed [39:0] prod_in;
   logic [41:0]        acc_base;
   logic signed [41:0] acc_in, rnd;
   logic signed [17:0] vs;
   logic signed [25:0] sum, sat;
   logic [25:0]        masked;
   logic signed [15:0] res;

   assign last_col = (c_ff == 2'd2);
   assign last_row = (r_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         XF_IDLE:   if (start) state_in = XF_INTERP;
         XF_INTERP: if (last_col) state_in = XF_MUL;
         XF_MUL:    state_in = XF_ADD;
         XF_ADD:    state_in = last_col ? XF_FIN : XF_MUL;
         XF_FIN:    state_in = last_row ? XF_IDLE : XF_MUL;
         default:   state_in = XF_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      ld_en     = 1'b0;
      interp_en = 1'b0;
      mul_en    = 1'b0;
      add_en    = 1'b0;
      fin_en    = 1'b0;
      case (state_ff)
         XF_IDLE:   ld_en = start;
         XF_INTERP: interp_en = 1'b1;
         XF_MUL:    mul_en = 1'b1;
         XF_ADD:    add_en = 1'b1;
         XF_FIN:    fin_en = 1'b1;
         default:   ld_en = 1'b0;
      endcase
   end

   // interpolation a*256 + (b-a)*f, exact in 24 bits
   always_comb begin
      a_c   = coord_pick(a_ff, c_ff);
      b_c   = coord_pick(b_ff, c_ff);
      diff  = {b_c[15], b_c} - {a_c[15], a_c};
      dprod = diff * $signed({1'b0, frac_ff});
      pval  = dprod + $signed({{2{a_c[15]}}, a_c, 8'd0});
      p_new = pval[23:0];
   end

   // one rotation term per multiply
   always_comb begin
      case (r_ff)
         2'd0:    row = rot_row_x;
         2'd1:    row = rot_row_y;
         default: row = rot_row_z;
      endcase
      case (c_ff)
         2'd0:    p_cur = px_ff;
         2'd1:    p_cur = py_ff;
         default: p_cur = pz_ff;
      endcase
      coef     = coef_pick(row, c_ff);
      prod_in  = coef * p_cur;
      acc_base = (c_ff == 2'd0) ? '0 : acc_ff;
      acc_in   = $signed(acc_base) + $signed({{2{prod_ff[39]}}, prod_ff});
   end

   // round to Q4.12, add offset, saturate
   always_comb begin
      rnd    = acc_ff + HALF;
      vs     = rnd[41:24];
      off    = coord_pick(offset_xyz, r_ff);
      sum    = $signed({{8{vs[17]}}, vs}) + $signed({{10{off[15]}}, off});
      if (sum > SAT_HI) begin
         sat = SAT_HI;
      end else if (sum < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = sum;
      end
      masked = sat & MASK;
      res    = masked[15:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= XF_IDLE;
         c_ff     <= '0;
         r_ff     <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fin_en && last_row;
         if (ld_en) begin
            c_ff <= '0;
            r_ff <= '0;
         end else begin
            if (interp_en || add_en) begin
               c_ff <= last_col ? 2'd0 : c_ff + 2'd1;
            end
            if (fin_en) begin
               r_ff <= last_row ? 2'd0 : r_ff + 2'd1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ld_en) begin
         a_ff    <= a_point;
         b_ff    <= b_point;
         frac_ff <= frac;
      end
      if (interp_en) begin
         case (c_ff)
            2'd0:    px_ff <= p_new;
            2'd1:    py_ff <= p_new;
            default: pz_ff <= p_new;
         endcase
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (add_en) begin
         acc_ff <= acc_in;
      end
      if (fin_en) begin
         case (r_ff)
            2'd0:    rx_ff <= res;
            2'd1:    ry_ff <= res;
            default: rz_ff <= res;
         endcase
      end
   end

   assign stat.done = done_ff;
   assign stat.x    = rx_ff;
   assign stat.y    = ry_ff;
   assign stat.z    = rz_ff;

endmodule

@@ hw/rtl/path_trail_interpolator.sv @@
// ----------------------------------------------------------------------------
// path_trail_interpolator
// Keeps a closed path of up to PATH_DEPTH 3-D waypoints in a ram. A load
// request writes one waypoint. A query request emits one trail point per
// step, each taken at query_time minus step times trail_spacing,
// interpolated between two neighboring waypoints, rotated, offset and
// saturated; the final point carries last. Only one request is worked on at
// a time: each trail point of a query takes the remainder that finds the
// waypoint index, two ram reads, and the interpolate/rotate unit, which
// does each of the three interpolations, a multiply and an add for each of
// the nine matrix terms and a rounding step per row. A point waits in the
// response register while the next one is computed; the block stalls only
// when that register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module path_trail_interpolator
   import ptrail_pkg::*;
#(
   parameter int PATH_DEPTH = 256,
   parameter int MAX_TRAIL  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]          csr_wdata
);

   localparam int         AW    = $clog2(PATH_DEPTH);
   localparam int         NCAP  = (PATH_DEPTH > 511) ? 511 : PATH_DEPTH;
   localparam logic [8:0] N_MAX = 9'(NCAP);
   localparam logic [6:0] T_MAX = 7'(MAX_TRAIL);

   // configuration registers
   logic [47:0] rot_x_ff, rot_y_ff, rot_z_ff, offset_ff;
   logic [8:0]  pcount_ff;
   logic [6:0]  tcount_ff;
   logic [15:0] spacing_cfg_ff;

   // sequencer
   top_state_type state_ff, state_in;
   logic [6:0]    i_ff;
   logic [6:0]    steps_ff;
   logic [8:0]    n_ff;
   logic [15:0]   spacing_ff;
   logic [23:0]   t_ff;
   logic [8:0]    k_ff;
   logic [47:0]   a_ff;
   logic          rsp_valid_ff;
   rsp_data_type  rsp_data_ff;

   logic          accept, wr_en, q_start, rem_go, cap_k, rd_sel_k, cap_a;
   logic          xf_start, emit, out_free, last_pt, in_range;
   logic [8:0]    n_calc;
   logic [6:0]    steps_calc;
   logic [9:0]    k_plus;
   logic [8:0]    k_next;
   logic [23:0]   t_next;
   logic [6:0]    i_plus;
   logic [47:0]   rd_data;
   logic [AW-1:0] rd_addr;

   rem_cmd_type   rem_cmd;
   rem_stat_type  rem_stat;
   xf_stat_type   xf_stat;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff       <= 48'h4000_0000_0000;
         rot_y_ff       <= 48'h0000_4000_0000;
         rot_z_ff       <= 48'h0000_0000_4000;
         offset_ff      <= '0;
         pcount_ff      <= 9'd1;
         tcount_ff      <= 7'd1;
         spacing_cfg_ff <= 16'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW_X:     rot_x_ff       <= csr_wdata;
            CSR_ROT_ROW_Y:     rot_y_ff       <= csr_wdata;
            CSR_ROT_ROW_Z:     rot_z_ff       <= csr_wdata;
            CSR_OFFSET_XYZ:    offset_ff      <= csr_wdata;
            CSR_POINT_COUNT:   pcount_ff      <= csr_wdata[8:0];
            CSR_TRAIL_COUNT:   tcount_ff      <= csr_wdata[6:0];
            CSR_TRAIL_SPACING: spacing_cfg_ff <= csr_wdata[15:0];
            default:           rot_x_ff       <= rot_x_ff;
         endcase
      end
   end

   // clamped counts
   always_comb begin
      if (pcount_ff == 9'd0) begin
         n_calc = 9'd1;
      end else if (pcount_ff > N_MAX) begin
         n_calc = N_MAX;
      end else begin
         n_calc = pcount_ff;
      end
      steps_calc = (tcount_ff > T_MAX) ? T_MAX : tcount_ff;
   end

   // step arithmetic
   always_comb begin
      k_plus   = {1'b0, k_ff} + 10'd1;
      k_next   = (k_plus == {1'b0, n_ff}) ? 9'd0 : k_plus[8:0];
      t_next   = t_ff - {8'd0, spacing_ff};
      i_plus   = i_ff + 7'd1;
      last_pt  = (i_plus == steps_ff) || (t_ff < {8'd0, spacing_ff});
      out_free = !rsp_valid_ff || rsp_ready;
      in_range = 32'(req_data.point_index) < 32'(PATH_DEPTH);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.mode == MODE_QUERY && steps_calc != 7'd0) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD:  if (rem_stat.done) state_in = ST_RDA;
         ST_RDA:  state_in = ST_RDB;
         ST_RDB:  state_in = ST_GO;
         ST_GO:   state_in = ST_XF;
         ST_XF:   if (xf_stat.done) state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_pt ? ST_IDLE : ST_MOD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      cap_k     = 1'b0;
      rd_sel_k  = 1'b0;
      cap_a     = 1'b0;
      xf_start  = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MOD:  cap_k = rem_stat.done;
         ST_RDA:  rd_sel_k = 1'b1;
         ST_RDB:  cap_a = 1'b1;
         ST_GO:   xf_start = 1'b1;
         ST_XF:   req_ready = 1'b0;
         ST_EMIT: emit = out_free;
         default: req_ready = 1'b0;
      endcase
      accept  = req_valid && req_ready;
      wr_en   = accept && req_data.mode == MODE_LOAD && in_range;
      q_start = accept && req_data.mode == MODE_QUERY && steps_calc != 7'd0;
      rem_go  = q_start || (emit && !last_pt);
   end

   // remainder command: first step from the request, later steps from t
   always_comb begin
      rem_cmd.start    = rem_go;
      rem_cmd.dividend = (state_ff == ST_IDLE) ? req_data.query_time[23:8] : t_next[23:8];
      rem_cmd.divisor  = (state_ff == ST_IDLE) ? n_calc : n_ff;
   end

   assign rd_addr = rd_sel_k ? AW'(k_ff) : AW'(k_next);

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         steps_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_start) begin
            i_ff     <= '0;
            steps_ff <= steps_calc;
         end else if (emit) begin
            i_ff <= i_plus;
         end
      end
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (q_start) begin
         t_ff       <= req_data.query_time;
         n_ff       <= n_calc;
         spacing_ff <= spacing_cfg_ff;
      end else if (emit) begin
         t_ff <= t_next;
      end
      if (cap_k) begin
         k_ff <= rem_stat.remainder;
      end
      if (cap_a) begin
         a_ff <= rd_data;
      end
      if (emit) begin
         rsp_data_ff.out_x <= xf_stat.x;
         rsp_data_ff.out_y <= xf_stat.y;
         rsp_data_ff.out_z <= xf_stat.z;
         rsp_data_ff.last  <= last_pt;
      end
   end

   // waypoint store
   ptrail_ram #(
      .WIDTH (48),
      .DEPTH (PATH_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.point_index)),
      .wr_data ({req_data.point_z, req_data.point_y, req_data.point_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // waypoint index remainder
   ptrail_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .stat  (rem_stat)
   );

   // interpolate and transform
   ptrail_xform u_xform (
      .clock      (clock),
      .reset      (reset),
      .start      (xf_start),
      .a_point    (a_ff),
      .b_point    (rd_data),
      .frac       (t_ff[7:0]),
      .rot_row_x  (rot_x_ff),
      .rot_row_y  (rot_y_ff),
      .rot_row_z  (rot_z_ff),
      .offset_xyz (offset_ff),
      .stat       (xf_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `PT_ASSERT(a_rem_done_in_mod, clock, reset, rem_stat.done |-> (state_ff == ST_MOD))
   `PT_ASSERT(a_xf_done_in_wait, clock, reset, xf_stat.done |-> (state_ff == ST_XF))
   `PT_ASSERT(a_step_in_range, clock, reset, (state_ff != ST_IDLE) |-> (i_ff < steps_ff))
   `PT_ASSERT(a_index_in_path, clock, reset, (state_ff == ST_RDA) |-> (k_ff < n_ff))
   `PT_ASSERT_NEVER(a_rem_busy_idle, clock, reset, rem_stat.busy && (state_ff == ST_IDLE))

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// path trail interpolator testbench
// Loads waypoints and sends trail queries through the request channel while
// both sides idle in random bursts. Accepted loads update a local copy of
// the path; accepted queries work out from it and the local configuration
// the trail points due; each response is compared with the oldest point due.
// Settings are changed between phases once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ptrail_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 150;
   localparam int MAX_REPORTS = 100;
   localparam logic [47:0] ROT_ID_X = 48'h4000_0000_0000;
   localparam logic [47:0] ROT_ID_Y = 48'h0000_4000_0000;
   localparam logic [47:0] ROT_ID_Z = 48'h0000_0000_4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_data_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_data_type         rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [47:0]          csr_wdata = '0;

   // local copy of configuration and path
   logic [47:0]        rot_row [0:2];
   logic [47:0]        pos_offset;
   logic [8:0]         path_len;
   logic [6:0]         trail_len;
   logic [15:0]        trail_step;
   logic signed [15:0] path_pt [0:255][0:2];

   req_data_type req_backlog [$];
   rsp_data_type trail_points_due [$];
   bit           slot_loaded [0:255];

   bit  req_fired = 1'b0;
   bit  next_valid;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  error_count = 0;
   int  load_count = 0;
   int  query_count = 0;
   int  point_count_seen = 0;
   int  setting_count = 0;
   longint cycle_count = 0;

   path_trail_interpolator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d trail points outstanding", $time,
                  trail_points_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   // effective sizes after the block's clamping
   function automatic int path_points(logic [8:0] v);
      return (v == 0) ? 1 : ((v > 256) ? 256 : int'(v));
   endfunction

   function automatic int trail_points(logic [6:0] v);
      return (v > 64) ? 64 : int'(v);
   endfunction

   // works out the trail points caused by one request
   function automatic void predict_trail(req_data_type rq);
      longint n, k, nx, t, f, acc, v;
      longint p [0:2];
      logic signed [15:0] coord [0:2];
      rsp_data_type pt;
      int steps, emitted;
      if (rq.mode == MODE_LOAD) begin
         path_pt[rq.point_index][0] = rq.point_x;
         path_pt[rq.point_index][1] = rq.point_y;
         path_pt[rq.point_index][2] = rq.point_z;
         return;
      end
      n = path_points(path_len);
      steps = trail_points(trail_len);
      emitted = 0;
      for (int i = 0; i < steps; i++) begin
         t = longint'(rq.query_time) - longint'(i) * longint'(trail_step);
         if (t < 0)
            break;
         k = (t >>> 8) % n;
         nx = (k + 1) % n;
         f = t & 255;
         for (int c = 0; c < 3; c++)
            p[c] = longint'(path_pt[k][c]) * (256 - f) + longint'(path_pt[nx][c]) * f;
         for (int r = 0; r < 3; r++) begin
            acc = longint'($signed(rot_row[r][47:32])) * p[0]
                + longint'($signed(rot_row[r][31:16])) * p[1]
                + longint'($signed(rot_row[r][15:0])) * p[2];
            // round half up from Q.36 to Q.12
            v = (acc + (64'sd1 <<< 23)) >>> 24;
            v = v + longint'($signed(pos_offset[16*r +: 16]));
            if (v > 32767)
               v = 32767;
            else if (v < -32768)
               v = -32768;
            coord[r] = v[15:0];
         end
         pt.out_x = coord[0];
         pt.out_y = coord[1];
         pt.out_z = coord[2];
         pt.last = 1'b0;
         trail_points_due = {trail_points_due, pt};
         emitted++;
      end
      if (emitted > 0)
         trail_points_due[trail_points_due.size() - 1].last = 1'b1;
   endfunction

   // request and response monitor
   always @(posedge clock) begin
      rsp_data_type e;
      if (!reset && req_valid && req_ready) begin
         predict_trail(req_data);
         req_fired = 1'b1;
         if (req_data.mode == MODE_LOAD)
            load_count++;
         else
            query_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         point_count_seen++;
         if (trail_points_due.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected trail point, expected none,", $time,
                        " got x=%0d y=%0d z=%0d last=%0b",
                        rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.last);
         end else begin
            e = trail_points_due.pop_front();
            if (rsp_data.out_x !== e.out_x || rsp_data.out_y !== e.out_y ||
                rsp_data.out_z !== e.out_z || rsp_data.last !== e.last) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: trail point mismatch,", $time,
                           " expected x=%0d y=%0d z=%0d last=%0b,",
                           e.out_x, e.out_y, e.out_z, e.last,
                           " got x=%0d y=%0d z=%0d last=%0b",
                           rsp_data.out_x, rsp_data.out_y, rsp_data.out_z, rsp_data.last);
            end
         end
      end
   end

   // request driver, fed from the backlog
   always @(negedge clock) begin
      next_valid = req_valid;
      if (req_fired) begin
         next_valid = 1'b0;
         req_fired = 1'b0;
      end
      if (!reset && !next_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (req_backlog.size() > 0) begin
            if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
               req_gap = $urandom_range(0, 14);
            end else begin
               req_data <= req_backlog.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_gap = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic void add_load(int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      req_data_type rq;
      rq.mode = MODE_LOAD;
      rq.point_index = idx[7:0];
      rq.point_x = x;
      rq.point_y = y;
      rq.point_z = z;
      rq.query_time = 24'($urandom());
      slot_loaded[idx[7:0]] = 1'b1;
      req_backlog = {req_backlog, rq};
   endfunction

   function automatic void add_query(logic [23:0] tm);
      req_data_type rq;
      rq.mode = MODE_QUERY;
      rq.point_index = 8'($urandom());
      rq.point_x = 16'($urandom());
      rq.point_y = 16'($urandom());
      rq.point_z = 16'($urandom());
      rq.query_time = tm;
      req_backlog = {req_backlog, rq};
   endfunction

   // load every slot a query may read that has not been written yet
   function automatic void fill_path(int n);
      for (int i = 0; i < n; i++)
         if (!slot_loaded[i])
            add_load(i, rand_coord(), rand_coord(), rand_coord());
   endfunction

   // wait for the block to drain, then for its latency
   task automatic settle();
      do
         @(posedge clock);
      while (req_backlog.size() > 0 || req_valid || trail_points_due.size() > 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ROT_ROW_X:     rot_row[0] = data;
         CSR_ROT_ROW_Y:     rot_row[1] = data;
         CSR_ROT_ROW_Z:     rot_row[2] = data;
         CSR_OFFSET_XYZ:    pos_offset = data;
         CSR_POINT_COUNT:   path_len = data[8:0];
         CSR_TRAIL_COUNT:   trail_len = data[6:0];
         CSR_TRAIL_SPACING: trail_step = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [47:0] rx, logic [47:0] ry, logic [47:0] rz,
                                 logic [47:0] off, logic [8:0] pc, logic [6:0] tc,
                                 logic [15:0] sp);
      settle();
      csr_write(CSR_ROT_ROW_X, rx);
      csr_write(CSR_ROT_ROW_Y, ry);
      csr_write(CSR_ROT_ROW_Z, rz);
      csr_write(CSR_OFFSET_XYZ, off);
      csr_write(CSR_POINT_COUNT, {39'd0, pc});
      csr_write(CSR_TRAIL_COUNT, {41'd0, tc});
      csr_write(CSR_TRAIL_SPACING, {32'd0, sp});
      setting_count++;
   endtask

   function automatic logic [47:0] rand_word48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic logic [47:0] rand_rot_row(int r);
      logic [47:0] w;
      case ($urandom_range(0, 4))
         0, 1: w = rand_word48();
         2, 3: begin
            w[47:32] = 16'($urandom_range(0, 32768) - 16384);
            w[31:16] = 16'($urandom_range(0, 32768) - 16384);
            w[15:0]  = 16'($urandom_range(0, 32768) - 16384);
         end
         default: w = (r == 0) ? ROT_ID_X : ((r == 1) ? ROT_ID_Y : ROT_ID_Z);
      endcase
      return w;
   endfunction

   // one random setting followed by a mix of loads and queries
   task automatic random_phase(int n_items, bit wide_path, bit quiet);
      logic [8:0] pc;
      logic [6:0] tc;
      logic [15:0] sp;
      logic [47:0] off;
      int n, steps, span, sel;
      if (wide_path) begin
         case ($urandom_range(0, 2))
            0: pc = 9'd256;
            1: pc = 9'd300;
            default: pc = 9'd511;
         endcase
         tc = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'd127;
      end else begin
         pc = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(1, 16)) : 9'($urandom_range(17, 64));
         tc = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(1, 12)) : 7'($urandom_range(13, 64));
      end
      case ($urandom_range(0, 3))
         0: sp = 16'($urandom_range(1, 65535));
         1: sp = 16'($urandom_range(1, 16));
         default: sp = 16'($urandom_range(1, 1024));
      endcase
      off = ($urandom_range(0, 1) == 0) ? rand_word48()
                                        : {16'($urandom_range(0, 8191) - 4096),
                                           16'($urandom_range(0, 8191) - 4096),
                                           16'($urandom_range(0, 8191) - 4096)};
      apply_settings(rand_rot_row(0), rand_rot_row(1), rand_rot_row(2), off, pc, tc, sp);
      if (quiet) begin
         gap_pct = 0;
         stall_pct = 0;
      end else begin
         gap_pct = $urandom_range(0, 2) * 15;
         stall_pct = $urandom_range(0, 2) * 15;
      end
      n = path_points(pc);
      steps = trail_points(tc);
      span = (steps - 1) * int'(sp);
      fill_path(n);
      for (int i = 0; i < n_items; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            add_load(($urandom_range(0, 9) < 6) ? $urandom_range(0, n - 1)
                                                : $urandom_range(0, 255),
                     rand_coord(), rand_coord(), rand_coord());
         end else if (sel < 42) begin
            // short times stop the trail early
            add_query(24'($urandom_range(0, span)));
         end else if (sel < 60) begin
            add_query(24'($urandom()));
         end else begin
            add_query(24'(span + $urandom_range(0, 24'hFFFFFF - span)));
         end
      end
   endtask

   initial begin
      rot_row[0] = ROT_ID_X;
      rot_row[1] = ROT_ID_Y;
      rot_row[2] = ROT_ID_Z;
      pos_offset = '0;
      path_len = 9'd1;
      trail_len = 7'd1;
      trail_step = 16'd256;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: single point path, extremes of time and slot
      setting_count = 1;
      add_load(0, 16'h7FFF, 16'h8000, 16'h0001);
      add_load(255, 16'h8000, 16'h7FFF, 16'hFFFF);
      add_query(24'h000000);
      add_query(24'hFFFFFF);

      // coefficients and offsets at their extremes, saturating output
      apply_settings({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h0000, 16'h0000},
                     {16'h0000, 16'h0000, 16'h4000}, {16'h8000, 16'h7FFF, 16'h7FFF},
                     9'd4, 7'd5, 16'h0080);
      gap_pct = 20;
      stall_pct = 20;
      add_load(0, 16'h7FFF, 16'h8000, 16'h7FFF);
      add_load(1, 16'h8000, 16'h7FFF, 16'h0000);
      add_load(2, 16'h0001, 16'hFFFF, 16'h4000);
      add_load(3, 16'h7FFF, 16'h7FFF, 16'h8000);
      add_query(24'h000000);
      add_query(24'h0003FF);
      add_query(24'h000200);
      add_query(24'hFFFFFF);

      // zero trail count with zero spacing and zero point count
      apply_settings(ROT_ID_X, ROT_ID_Y, ROT_ID_Z, 48'd0, 9'd0, 7'd0, 16'd0);
      add_query(24'h123456);
      // trail count above the maximum, every point at the same time
      apply_settings(ROT_ID_X, ROT_ID_Y, ROT_ID_Z, 48'd0, 9'd0, 7'd100, 16'd0);
      add_query(24'h0000C0);
      // widest spacing, full and early-stopped trails
      apply_settings(ROT_ID_Z, ROT_ID_X, ROT_ID_Y, 48'h0001_FFFF_8000, 9'd4, 7'd64, 16'hFFFF);
      add_query(24'hFFFFFF);
      add_query(24'h00FFFF);

      for (int ph = 0; ph < 7; ph++)
         random_phase(10, 1'b0, 1'b0);
      random_phase(10, 1'b1, 1'b0);
      random_phase(10, 1'b0, 1'b1);
      random_phase(10, 1'b0, 1'b1);

      settle();
      if (trail_points_due.size() != 0)
         error_count++;
      $display("%0d requests accepted (%0d loads, %0d queries) over %0d register settings",
               load_count + query_count, load_count, query_count, setting_count);
      $display("%0d trail points compared, %0d mismatches", point_count_seen, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
